[sv/timer_interrupt_unit_assert.svh]
// Assertion macros for the timer and interrupt unit.
// Included by the top level only; no other dependencies.
`ifndef TIMER_INTERRUPT_UNIT_ASSERT_SVH
`define TIMER_INTERRUPT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TIU_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("tiu assertion failed");

// Next-cycle implication, checked outside reset.
`define TIU_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("tiu assertion failed");

`endif

[sv/tiu_pkg.sv]
// Shared types and constants of the timer and interrupt unit.
// No dependencies.
package tiu_pkg;

   localparam int unsigned LC_W   = 10;
   localparam int unsigned ADDR_W = 13;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned CYC_W  = 10;
   localparam int unsigned LINE_W = 3;
   localparam int unsigned PRE_W  = 12;

   localparam logic [LC_W-1:0]   LINE_CYCLES_RESET = 10'd113;
   localparam logic [PRE_W:0]    TICK_PERIOD       = 13'd1024;
   localparam logic [PRE_W:0]    PRE_FLOOR         = 13'h1800;
   localparam logic [ADDR_W-1:0] PAGE_MASK         = 13'h1F00;
   localparam logic [ADDR_W-1:0] TIMER_PAGE        = 13'h0C00;
   localparam logic [ADDR_W-1:0] IRQ_PAGE          = 13'h1400;
   localparam logic [ADDR_W-1:0] WIN_LO            = 13'h0800;
   localparam logic [ADDR_W-1:0] WIN_HI            = 13'h1800;
   localparam logic [LINE_W-1:0] TIMER_BIT         = 3'b100;
   localparam logic [1:0]        OFS_MASK          = 2'd2;
   localparam logic [1:0]        OFS_STATUS        = 2'd3;
   localparam logic [DATA_W-1:0] NO_DATA           = 8'hFF;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] io_address;
      logic [DATA_W-1:0] write_data;
      logic [CYC_W-1:0]  cycles_in_line;
      logic [LINE_W-1:0] irq_request;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [LINE_W-1:0] irq_pending;
      logic [LINE_W-1:0] irq_enable_mask;
   } rsp_type;

endpackage

[sv/tiu_input_stage.sv]
// Input register of the timer and interrupt unit: holds one request.
// Depends on tiu_pkg.
module tiu_input_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tiu_pkg::req_type req_in,
   input  logic             advance,
   output logic             held_valid,
   output tiu_pkg::req_type held_req
);

   logic             valid_ff;
   logic             valid_in;
   tiu_pkg::req_type req_ff;
   logic             take;

   assign req_stall  = valid_ff && !advance;
   assign take       = req_valid && !req_stall;
   assign held_valid = valid_ff;
   assign held_req   = req_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
   end

endmodule

[sv/tiu_core.sv]
// Timer, interrupt and bus latch state with the per-request update logic.
// Depends on tiu_pkg.
module tiu_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [tiu_pkg::LC_W-1:0]   csr_data,
   input  logic                       step,
   input  tiu_pkg::req_type           req,
   output tiu_pkg::rsp_type           rsp
);

   logic [tiu_pkg::LC_W-1:0]   line_cycles_ff;
   logic [tiu_pkg::PRE_W-1:0]  prescaler_ff,   prescaler_in;
   logic [7:0]                 counter_ff,     counter_in;
   logic [6:0]                 reload_ff,      reload_in;
   logic                       running_ff,     running_in;
   logic [tiu_pkg::LINE_W-1:0] lines_ff,       lines_in;
   logic [tiu_pkg::LINE_W-1:0] mask_ff,        mask_in;
   logic [7:0]                 latch_ff,       latch_in;

   logic [tiu_pkg::PRE_W:0]    diff;
   logic [tiu_pkg::PRE_W:0]    sat;
   logic [7:0]                 cnt;
   logic [7:0]                 cnt_m1;
   logic [7:0]                 rd;
   logic [tiu_pkg::ADDR_W-1:0] page;
   logic                       in_win;
   logic                       pre_match;

   always_comb begin
      page      = req.io_address & tiu_pkg::PAGE_MASK;
      in_win    = (req.io_address >= tiu_pkg::WIN_LO) && (req.io_address < tiu_pkg::WIN_HI);
      diff      = {prescaler_ff[tiu_pkg::PRE_W-1], prescaler_ff}
                  - {3'b000, line_cycles_ff};
      // below -2048: sign set, next bit clear
      sat       = (diff[tiu_pkg::PRE_W] && !diff[tiu_pkg::PRE_W-1]) ? tiu_pkg::PRE_FLOOR : diff;
      cnt_m1    = counter_ff - 8'd1;
      pre_match = !prescaler_ff[tiu_pkg::PRE_W-1]
                  && (prescaler_ff == {2'b00, req.cycles_in_line});

      prescaler_in = prescaler_ff;
      counter_in   = counter_ff;
      reload_in    = reload_ff;
      running_in   = running_ff;
      lines_in     = lines_ff | req.irq_request;
      mask_in      = mask_ff;
      latch_in     = latch_ff;
      rd           = tiu_pkg::NO_DATA;
      cnt          = counter_ff;

      unique case (req.kind)
         tiu_pkg::KIND_TICK: begin
            if (sat[tiu_pkg::PRE_W]) begin
               prescaler_in = tiu_pkg::PRE_W'(sat + tiu_pkg::TICK_PERIOD);
               if (running_ff) begin
                  if (cnt[7]) begin
                     cnt      = {1'b0, reload_ff};
                     lines_in = lines_in | tiu_pkg::TIMER_BIT;
                  end
                  counter_in = cnt - 8'd1;
               end
            end else begin
               prescaler_in = sat[tiu_pkg::PRE_W-1:0];
            end
         end
         tiu_pkg::KIND_READ: begin
            rd = in_win ? latch_ff : tiu_pkg::NO_DATA;
            if (page == tiu_pkg::TIMER_PAGE) begin
               rd = {latch_ff[7], 7'd0} | (pre_match ? {1'b0, cnt_m1[6:0]} : counter_ff);
            end else if (page == tiu_pkg::IRQ_PAGE) begin
               if (req.io_address[1:0] == tiu_pkg::OFS_MASK) begin
                  rd = {latch_ff[7:3], mask_ff};
               end else if (req.io_address[1:0] == tiu_pkg::OFS_STATUS) begin
                  rd       = {5'd0, lines_in};
                  lines_in = '0;
               end
            end
            if (in_win) begin
               latch_in = rd;
            end
         end
         tiu_pkg::KIND_WRITE: begin
            if (in_win) begin
               latch_in = req.write_data;
            end
            if (page == tiu_pkg::TIMER_PAGE) begin
               if (!req.io_address[0]) begin
                  reload_in = req.write_data[6:0];
               end else begin
                  if (req.write_data[0] && !running_ff) begin
                     counter_in = {1'b0, reload_ff};
                  end
                  running_in = req.write_data[0];
               end
            end else if (page == tiu_pkg::IRQ_PAGE) begin
               if (req.io_address[1:0] == tiu_pkg::OFS_MASK) begin
                  mask_in = req.write_data[tiu_pkg::LINE_W-1:0];
               end else if (req.io_address[1:0] == tiu_pkg::OFS_STATUS) begin
                  lines_in = lines_in & ~tiu_pkg::TIMER_BIT;
               end
            end
         end
         tiu_pkg::KIND_OTHER: begin
            if (in_win) begin
               latch_in = req.write_data;
            end
         end
         default: begin
         end
      endcase

      rsp.read_data       = rd;
      rsp.irq_pending     = lines_in;
      rsp.irq_enable_mask = mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cycles_ff <= tiu_pkg::LINE_CYCLES_RESET;
         prescaler_ff   <= '0;
         counter_ff     <= '0;
         reload_ff      <= '0;
         running_ff     <= 1'b0;
         lines_ff       <= '0;
         mask_ff        <= '0;
         latch_ff       <= '0;
      end else begin
         if (csr_write) begin
            line_cycles_ff <= csr_data;
         end
         if (step) begin
            prescaler_ff <= prescaler_in;
            counter_ff   <= counter_in;
            reload_ff    <= reload_in;
            running_ff   <= running_in;
            lines_ff     <= lines_in;
            mask_ff      <= mask_in;
            latch_ff     <= latch_in;
         end
      end
   end

endmodule

[sv/timer_interrupt_unit.sv]
// Timer and interrupt unit: line-tick prescaler, 8-bit down counter with reload,
// interrupt lines and mask, shared I/O bus latch. Uses tiu_pkg, tiu_input_stage, tiu_core.
//
// Every request yields exactly one response, registered in tiu_input_stage and then in
// the output register once it is free; a stalled response holds the request behind it.
// Requests are taken one per clock while the output is not stalled; tiu_core computes
// each state update combinationally. line_cycles is written through the csr port, which
// is always ready; write it only while no request is in flight.
module timer_interrupt_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tiu_pkg::LC_W-1:0]      csr_line_cycles,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [tiu_pkg::ADDR_W-1:0]    req_io_address,
   input  logic [tiu_pkg::DATA_W-1:0]    req_write_data,
   input  logic [tiu_pkg::CYC_W-1:0]     req_cycles_in_line,
   input  logic [tiu_pkg::LINE_W-1:0]    req_irq_request,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tiu_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [tiu_pkg::LINE_W-1:0]    rsp_irq_pending,
   output logic [tiu_pkg::LINE_W-1:0]    rsp_irq_enable_mask
);

   tiu_pkg::req_type req_in;
   tiu_pkg::req_type held_req;
   tiu_pkg::rsp_type core_rsp;
   tiu_pkg::rsp_type rsp_ff;
   logic             held_valid;
   logic             advance;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   assign req_in.kind           = tiu_pkg::kind_type'(req_kind);
   assign req_in.io_address     = req_io_address;
   assign req_in.write_data     = req_write_data;
   assign req_in.cycles_in_line = req_cycles_in_line;
   assign req_in.irq_request    = req_irq_request;

   assign csr_ready = 1'b1;
   assign advance   = held_valid && (!rsp_valid_ff || !rsp_stall);

   tiu_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_in     (req_in),
      .advance    (advance),
      .held_valid (held_valid),
      .held_req   (held_req)
   );

   tiu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_line_cycles),
      .step      (advance),
      .req       (held_req),
      .rsp       (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_irq_pending     = rsp_ff.irq_pending;
   assign rsp_irq_enable_mask = rsp_ff.irq_enable_mask;

`include "timer_interrupt_unit_assert.svh"

   // input backs up only behind a full, stalled output
   `TIU_ASSERT_IMPLY(a_stall_needs_full_out, clock, reset, req_stall, rsp_valid_ff && rsp_stall)
   // a taken response with nothing behind it leaves the output empty
   `TIU_ASSERT_NEXT(a_no_dup_rsp, clock, reset, rsp_valid_ff && !rsp_stall && !held_valid, !rsp_valid_ff)
   // a held request moves on whenever the output can take it
   `TIU_ASSERT_IMPLY(a_held_moves, clock, reset, held_valid && !rsp_valid_ff, advance)

endmodule
